// ----- rtl/hgv_pkg.sv -----
// Shared types, character constants and match tables for the HTTP GET validator.
// No dependencies; hgv_core and the top level refer to it by scoped names.
package hgv_pkg;

    // Grammar position within the request text
    typedef enum logic [3:0] {
        PH_FIRST_NL = 4'd0,
        PH_W1_SP    = 4'd1,
        PH_W1       = 4'd2,
        PH_W2_SP    = 4'd3,
        PH_W2       = 4'd4,
        PH_W3_SP    = 4'd5,
        PH_W3       = 4'd6,
        PH_REST0    = 4'd7,
        PH_NL       = 4'd8,
        PH_LINE     = 4'd9
    } t_phase;

    typedef enum logic [1:0] {
        VERDICT_OK     = 2'd0,
        VERDICT_BAD    = 2'd1,
        VERDICT_NOHOST = 2'd2
    } t_verdict;

    // One result word
    typedef struct packed {
        logic       path_valid;
        logic [7:0] path_byte;
        logic       verdict_valid;
        logic [1:0] verdict;
    } t_result;

    localparam logic [7:0] CHAR_NUL = 8'h00;
    localparam logic [7:0] CHAR_SP  = 8'h20;
    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_LF  = 8'h0A;

    localparam logic [3:0] GET_LEN   = 4'd3;
    localparam logic [3:0] PROTO_LEN = 4'd8;
    localparam logic [2:0] HOST_LEN  = 3'd6;

    // "GET"
    function automatic logic [7:0] get_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = 8'h47;
            2'd1:    c = 8'h45;
            2'd2:    c = 8'h54;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "HTTP/1.1"
    function automatic logic [7:0] proto_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h48;
            3'd1:    c = 8'h54;
            3'd2:    c = 8'h54;
            3'd3:    c = 8'h50;
            3'd4:    c = 8'h2F;
            3'd5:    c = 8'h31;
            3'd6:    c = 8'h2E;
            3'd7:    c = 8'h31;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "Host: "
    function automatic logic [7:0] host_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h48;
            3'd1:    c = 8'h6F;
            3'd2:    c = 8'h73;
            3'd3:    c = 8'h74;
            3'd4:    c = 8'h3A;
            3'd5:    c = 8'h20;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/hgv_in_if.sv -----
// Input channel: one request text byte per word, valid/ready handshake.
// Depends on nothing.
interface hgv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       final_byte;

    modport source (output valid, output text_byte, output final_byte, input ready);
    modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

// ----- rtl/hgv_out_if.sv -----
// Output channel: path byte and verdict per word, valid/ready handshake.
// Depends on nothing.
interface hgv_out_if;
    logic       valid;
    logic       ready;
    logic       path_valid;
    logic [7:0] path_byte;
    logic       verdict_valid;
    logic [1:0] verdict;

    modport source (output valid, output path_valid, output path_byte,
                    output verdict_valid, output verdict, input ready);
    modport sink   (input valid, input path_valid, input path_byte,
                    input verdict_valid, input verdict, output ready);
endinterface

// ----- rtl/hgv_core.sv -----
// Request grammar state and the per-byte step logic of the GET validator.
// Depends on hgv_pkg.
module hgv_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic [7:0]       i_text_byte,
    input  logic             i_final_byte,
    output hgv_pkg::t_result o_result
);

    hgv_pkg::t_phase   r_phase,   n_phase;
    logic [3:0]        r_match,   n_match;
    logic [2:0]        r_host,    n_host;
    logic              r_host_ok, n_host_ok;
    logic              r_decided, n_decided;
    hgv_pkg::t_verdict r_verdict, n_verdict;

    logic sp;
    logic eol;
    logic ending;
    logic path;

    assign sp     = (i_text_byte == hgv_pkg::CHAR_SP);
    assign eol    = (i_text_byte == hgv_pkg::CHAR_CR) || (i_text_byte == hgv_pkg::CHAR_LF);
    assign ending = i_final_byte || (i_text_byte == hgv_pkg::CHAR_NUL);

    // Step: consume one byte, settle the verdict once it is fixed or at the end of text
    always_comb begin
        n_phase   = r_phase;
        n_match   = r_match;
        n_host    = r_host;
        n_host_ok = r_host_ok;
        n_decided = r_decided;
        n_verdict = r_verdict;
        path      = 1'b0;

        if ((i_text_byte != hgv_pkg::CHAR_NUL) && !r_decided) begin
            case (r_phase)
                hgv_pkg::PH_FIRST_NL, hgv_pkg::PH_W1_SP: begin
                    if (eol) begin
                        // blank lines before the request line are skipped
                        if (r_phase == hgv_pkg::PH_W1_SP) begin
                            n_decided = 1'b1;
                            n_verdict = hgv_pkg::VERDICT_BAD;
                        end
                    end else if (sp) begin
                        n_phase = hgv_pkg::PH_W1_SP;
                    end else begin
                        n_phase = hgv_pkg::PH_W1;
                        if (i_text_byte == hgv_pkg::get_char(2'd0)) begin
                            n_match = 4'd1;
                        end else begin
                            n_match   = 4'd0;
                            n_decided = 1'b1;
                            n_verdict = hgv_pkg::VERDICT_BAD;
                        end
                    end
                end
                hgv_pkg::PH_W1: begin
                    if (sp) begin
                        if (r_match == hgv_pkg::GET_LEN) begin
                            n_phase = hgv_pkg::PH_W2_SP;
                        end else begin
                            n_decided = 1'b1;
                            n_verdict = hgv_pkg::VERDICT_BAD;
                        end
                    end else if (!eol && (r_match < hgv_pkg::GET_LEN) &&
                                 (i_text_byte == hgv_pkg::get_char(r_match[1:0]))) begin
                        n_match = r_match + 4'd1;
                    end else begin
                        n_decided = 1'b1;
                        n_verdict = hgv_pkg::VERDICT_BAD;
                    end
                end
                hgv_pkg::PH_W2_SP, hgv_pkg::PH_W2: begin
                    if (sp) begin
                        if (r_phase == hgv_pkg::PH_W2) begin
                            n_phase = hgv_pkg::PH_W3_SP;
                        end
                    end else if (eol) begin
                        n_decided = 1'b1;
                        n_verdict = hgv_pkg::VERDICT_BAD;
                    end else begin
                        n_phase = hgv_pkg::PH_W2;
                        path    = 1'b1;
                    end
                end
                hgv_pkg::PH_W3_SP: begin
                    if (eol) begin
                        n_decided = 1'b1;
                        n_verdict = hgv_pkg::VERDICT_BAD;
                    end else if (!sp) begin
                        n_phase = hgv_pkg::PH_W3;
                        if (i_text_byte == hgv_pkg::proto_char(3'd0)) begin
                            n_match = 4'd1;
                        end else begin
                            n_match   = 4'd0;
                            n_decided = 1'b1;
                            n_verdict = hgv_pkg::VERDICT_BAD;
                        end
                    end
                end
                hgv_pkg::PH_W3: begin
                    if (sp || eol) begin
                        if (r_match == hgv_pkg::PROTO_LEN) begin
                            n_phase = eol ? hgv_pkg::PH_NL : hgv_pkg::PH_REST0;
                        end else begin
                            n_decided = 1'b1;
                            n_verdict = hgv_pkg::VERDICT_BAD;
                        end
                    end else if ((r_match < hgv_pkg::PROTO_LEN) &&
                                 (i_text_byte == hgv_pkg::proto_char(r_match[2:0]))) begin
                        n_match = r_match + 4'd1;
                    end else begin
                        n_decided = 1'b1;
                        n_verdict = hgv_pkg::VERDICT_BAD;
                    end
                end
                hgv_pkg::PH_REST0: begin
                    // trailing words of the request line are ignored
                    if (eol) begin
                        n_phase = hgv_pkg::PH_NL;
                    end
                end
                hgv_pkg::PH_NL: begin
                    if (!eol) begin
                        n_phase = hgv_pkg::PH_LINE;
                        if (i_text_byte == hgv_pkg::host_char(3'd0)) begin
                            n_host    = 3'd1;
                            n_host_ok = 1'b1;
                        end else begin
                            n_host    = 3'd0;
                            n_host_ok = 1'b0;
                        end
                    end
                end
                hgv_pkg::PH_LINE: begin
                    if (eol) begin
                        n_phase = hgv_pkg::PH_NL;
                    end else if (r_host_ok) begin
                        if (r_host < hgv_pkg::HOST_LEN) begin
                            if (i_text_byte == hgv_pkg::host_char(r_host)) begin
                                n_host = r_host + 3'd1;
                            end else begin
                                n_host_ok = 1'b0;
                            end
                        end else begin
                            // one more character after "Host: "
                            n_decided = 1'b1;
                            n_verdict = hgv_pkg::VERDICT_OK;
                        end
                    end
                end
                default: begin
                    n_decided = 1'b1;
                    n_verdict = hgv_pkg::VERDICT_BAD;
                end
            endcase
        end

        // End of text without a verdict yet
        if (ending && !n_decided) begin
            n_decided = 1'b1;
            if ((n_phase == hgv_pkg::PH_REST0) || (n_phase == hgv_pkg::PH_NL) ||
                (n_phase == hgv_pkg::PH_LINE) ||
                ((n_phase == hgv_pkg::PH_W3) && (n_match == hgv_pkg::PROTO_LEN))) begin
                n_verdict = hgv_pkg::VERDICT_NOHOST;
            end else begin
                n_verdict = hgv_pkg::VERDICT_BAD;
            end
        end

        o_result.path_valid    = path;
        o_result.path_byte     = path ? i_text_byte : 8'h00;
        o_result.verdict_valid = n_decided;
        o_result.verdict       = n_decided ? n_verdict : 2'd0;

        // back to the start for the next request
        if (ending) begin
            n_phase   = hgv_pkg::PH_FIRST_NL;
            n_match   = 4'd0;
            n_host    = 3'd0;
            n_host_ok = 1'b1;
            n_decided = 1'b0;
            n_verdict = hgv_pkg::VERDICT_OK;
        end
    end

    // State registers advance once per consumed word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= hgv_pkg::PH_FIRST_NL;
            r_match   <= 4'd0;
            r_host    <= 3'd0;
            r_host_ok <= 1'b1;
            r_decided <= 1'b0;
            r_verdict <= hgv_pkg::VERDICT_OK;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_match   <= n_match;
            r_host    <= n_host;
            r_host_ok <= n_host_ok;
            r_decided <= n_decided;
            r_verdict <= n_verdict;
        end
    end

endmodule

// ----- rtl/http_get_request_validator.sv -----
// Top level of the HTTP GET request validator: input register, step core, result register.
// Depends on hgv_pkg, hgv_in_if, hgv_out_if and hgv_core.

// Takes request text one byte per word and returns exactly one result word per
// input word: a path byte while the second word of the request line streams by,
// and the verdict (0 ok, 1 bad request line, 2 no Host line) once it is fixed and
// always on the word that ends the text (a zero byte or final_byte set). One word
// is accepted every clock cycle while the result side is ready; each result passes
// through the input register and then the combinational grammar step that loads
// the result register. Backpressure on the result side holds the pipeline; no
// word is dropped.
module http_get_request_validator (
    input  logic   i_clk,
    input  logic   i_rst_n,
    hgv_in_if.sink  i_req,
    hgv_out_if.source o_res
);

    logic             r_in_valid;
    logic [7:0]       r_text_byte;
    logic             r_final_byte;
    logic             r_out_valid;
    hgv_pkg::t_result r_result;
    hgv_pkg::t_result step_result;
    logic             adv;

    // Step fires when a word waits and the result register is free
    assign adv         = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_req.ready = !r_in_valid || adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_text_byte  <= i_req.text_byte;
            r_final_byte <= i_req.final_byte;
        end
    end

    hgv_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (adv),
        .i_text_byte  (r_text_byte),
        .i_final_byte (r_final_byte),
        .o_result     (step_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_result <= step_result;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.path_valid    = r_result.path_valid;
    assign o_res.path_byte     = r_result.path_byte;
    assign o_res.verdict_valid = r_result.verdict_valid;
    assign o_res.verdict       = r_result.verdict;

endmodule
